@@ rtl/core/lcct_pkg.sv @@
// lcct_pkg: shared types, constants and helpers for the log counter context table.
// Depends on nothing; imported by lcct_ctrl, lcct_dpath and log_counter_context_table.
package lcct_pkg;

  localparam int unsigned CTX_W   = 14;
  localparam int unsigned LOG_W   = 6;
  localparam int unsigned COUNT_W = 63;
  localparam int unsigned TICK_W  = 64;
  localparam int unsigned OFS_W   = 2;   // four entries per query

  localparam logic [LOG_W-1:0] LOG_MAX = 6'd63;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;   // clearing pass: write zero, step sweep address
    logic capture;  // transfer taken: latch address, reset offset
    logic upd_rd;   // update: read the entry
    logic upd_wr;   // update: conditional write-back, tick advance
    logic qry_rd;   // query: read entry at base + offset
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic ofs_last;
  } sts_t;

  // 2^v - 1 as a 63-bit mask
  function automatic logic [COUNT_W-1:0] approx_count(input logic [LOG_W-1:0] v);
    logic [LOG_W-1:0] sh;
    sh = LOG_MAX - v;
    return {COUNT_W{1'b1}} >> sh;
  endfunction

endpackage

@@ rtl/core/lcct_ctrl.sv @@
// lcct_ctrl: sequencer for clearing, update read-modify-write and four-entry query.
// Depends on lcct_pkg (cmd_t, sts_t, mode codes).
module lcct_ctrl
  import lcct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic mode_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic valid_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_UPD_RD = 3'd2;
  localparam logic [2:0] ST_UPD_WR = 3'd3;
  localparam logic [2:0] ST_QRY_RD = 3'd4;
  localparam logic [2:0] ST_QRY_WT = 3'd5;
  localparam logic [2:0] ST_QRY_OUT = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = (mode_i == MODE_QUERY) ? ST_QRY_RD : ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        cmd_o.upd_rd = 1'b1;
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRY_RD: begin
        cmd_o.qry_rd = 1'b1;
        if (sts_i.ofs_last) state_d = ST_QRY_WT;
      end
      ST_QRY_WT: begin
        state_d = ST_QRY_OUT;
      end
      ST_QRY_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_QRY_OUT);

endmodule

@@ rtl/core/lcct_dpath.sv @@
// lcct_dpath: log value memory, update tick, address/offset counters, query result registers.
// Depends on lcct_pkg (cmd_t, sts_t, widths, approx_count).
module lcct_dpath
  import lcct_pkg::*;
#(
  parameter int unsigned CONTEXT_ORDER = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [CTX_W-1:0]   context_req_i,
  output logic [COUNT_W-1:0] count_first_o,
  output logic [COUNT_W-1:0] count_second_o,
  output logic [COUNT_W-1:0] count_third_o,
  output logic [COUNT_W-1:0] count_fourth_o
);

  localparam int unsigned AW    = 2 * CONTEXT_ORDER + 2;
  localparam int unsigned DEPTH = 1 << AW;

  logic [LOG_W-1:0]  mem [DEPTH];
  logic [LOG_W-1:0]  rdata_q;
  logic [AW-1:0]     base_q;
  logic [AW-1:0]     clr_q;
  logic [OFS_W-1:0]  ofs_q;
  logic [TICK_W-1:0] tick_q;
  logic              rd_pend_q;
  logic [LOG_W-1:0]  res_q [4];

  logic [AW-1:0]     addr;
  logic              we;
  logic [LOG_W-1:0]  wdata;
  logic              hit;

  // counter takes the update when the low v bits of the tick are all zero
  assign hit = ((tick_q[COUNT_W-1:0] & approx_count(rdata_q)) == '0);

  always_comb begin
    addr  = base_q;
    we    = 1'b0;
    wdata = '0;
    if (cmd_i.clr_wr) begin
      addr = clr_q;
      we   = 1'b1;
    end else if (cmd_i.upd_rd) begin
      addr = base_q;                // entry to be updated
    end else if (cmd_i.upd_wr) begin
      we    = hit && (rdata_q != LOG_MAX);
      wdata = rdata_q + LOG_W'(1);
    end else if (cmd_i.qry_rd) begin
      addr = base_q + AW'(ofs_q);   // wraps at table end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      ofs_q     <= '0;
      tick_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.qry_rd;
      if (cmd_i.clr_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.capture) begin
        ofs_q <= '0;
      end else if (cmd_i.qry_rd) begin
        ofs_q <= ofs_q + OFS_W'(1);
      end
      if (cmd_i.upd_wr) tick_q <= tick_q + TICK_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) base_q <= AW'(context_req_i);
    if (rd_pend_q) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
      res_q[2] <= res_q[3];
      res_q[3] <= rdata_q;
    end
  end

  assign sts_o.clr_last = &clr_q;
  assign sts_o.ofs_last = &ofs_q;

  assign count_first_o  = approx_count(res_q[0]);
  assign count_second_o = approx_count(res_q[1]);
  assign count_third_o  = approx_count(res_q[2]);
  assign count_fourth_o = approx_count(res_q[3]);

endmodule

@@ rtl/core/log_counter_context_table.sv @@
// log_counter_context_table: top level, approximate log counter table per DNA context.
// Depends on lcct_pkg, lcct_ctrl, lcct_dpath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  command  | start_i, busy_o           | mode_i, context_req_i
//  result   | valid_o (1-cycle strobe)  | count_first_o .. count_fourth_o
//
// Sequencing: a command transfer is taken when start_i is high and busy_o low.
//   Update: accept, memory read, write-back, then busy_o drops; a read-modify-write on
//   the single-port memory. Query: accept, four reads on the single port, a read wait
//   state, result strobe; valid_o is high in the result strobe step.
// Reset: async, active low. After reset a clearing pass writes zero to every entry,
//   one per cycle over 4^(CONTEXT_ORDER+1) entries (16384 by default), busy_o high.
// Stalls: the receiver cannot stall; valid_o marks each result for one cycle only.
// Addresses wrap modulo the table size; log values saturate at 63; tick wraps at 2^64.
module log_counter_context_table
  import lcct_pkg::*;
#(
  parameter int unsigned CONTEXT_ORDER = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [CTX_W-1:0]   context_req_i,
  output logic               valid_o,
  output logic [COUNT_W-1:0] count_first_o,
  output logic [COUNT_W-1:0] count_second_o,
  output logic [COUNT_W-1:0] count_third_o,
  output logic [COUNT_W-1:0] count_fourth_o
);

  cmd_t cmd;
  sts_t sts;

  lcct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  lcct_dpath #(
    .CONTEXT_ORDER (CONTEXT_ORDER)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .context_req_i  (context_req_i),
    .count_first_o  (count_first_o),
    .count_second_o (count_second_o),
    .count_third_o  (count_third_o),
    .count_fourth_o (count_fourth_o)
  );

endmodule

@@ sim/log_counter_context_table_tb.sv @@
// log_counter_context_table_tb: self-checking bench for the approximate log counter table.
// Depends on lcct_pkg and log_counter_context_table; a behavioural copy of the table and
// tick predicts unfixed query results; all are checked field by field as they strobe out.
`timescale 1ns / 100ps

module log_counter_context_table_tb;
  import lcct_pkg::*;

  localparam int unsigned CONTEXT_ORDER = 6;
  localparam int unsigned TBL_AW        = 2 * CONTEXT_ORDER + 2;
  localparam int unsigned TBL_DEPTH     = 4 << (2 * CONTEXT_ORDER);
  localparam int unsigned RAND_N        = 1225;
  localparam int unsigned CALM_LEN      = 300;   // stretch of back-to-back transfers
  localparam int unsigned END_TAIL      = 20;
  // the clearing pass plus ~1250 transfers with their busy time and idle gaps,
  // taken several times over
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // four approximate counts of one query, slot 0 = entry at the given address
  typedef logic [0:3][COUNT_W-1:0] quad_t;

  typedef struct packed {
    logic             mode;
    logic [CTX_W-1:0] ctx;
    logic             fixed;   // expected counts typed in below, not predicted
    quad_t            counts;
  } dir_row_t;

  localparam int unsigned DIR_N = 22;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               mode_i;
  logic [CTX_W-1:0]   context_req_i;
  logic               valid_o;
  logic [COUNT_W-1:0] count_first_o;
  logic [COUNT_W-1:0] count_second_o;
  logic [COUNT_W-1:0] count_third_o;
  logic [COUNT_W-1:0] count_fourth_o;

  // hand-typed expectation travelling alongside the command
  logic  fixed_use;
  quad_t fixed_quad;

  // behavioural copy of the counter table and the shared tick
  logic [LOG_W-1:0]  log_tbl [TBL_DEPTH];
  logic [TICK_W-1:0] upd_tick;

  quad_t       counts_due [$];
  int unsigned err_cnt    = 0;
  int unsigned result_cnt = 0;
  int unsigned cyc_cnt    = 0;

  dir_row_t dir_rows [DIR_N];

  log_counter_context_table #(
    .CONTEXT_ORDER (CONTEXT_ORDER)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .context_req_i  (context_req_i),
    .valid_o        (valid_o),
    .count_first_o  (count_first_o),
    .count_second_o (count_second_o),
    .count_third_o  (count_third_o),
    .count_fourth_o (count_fourth_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // log value v stands for 2^v - 1
  function automatic logic [COUNT_W-1:0] count_of(input logic [LOG_W-1:0] v);
    logic [TICK_W-1:0] full;
    full = (TICK_W'(1) << v) - TICK_W'(1);
    return full[COUNT_W-1:0];
  endfunction

  // update: bump the entry only when the tick, before it moves, clears the
  // entry's mask; saturate at the top log value; the tick always advances
  // and wraps at 2^64
  task automatic bump_counter(input logic [CTX_W-1:0] ctx);
    logic [TBL_AW-1:0] idx;
    logic [LOG_W-1:0]  v;
    idx = TBL_AW'(ctx);
    v   = log_tbl[idx];
    if (((upd_tick & {1'b0, count_of(v)}) == '0) && (v != LOG_MAX)) begin
      log_tbl[idx] = v + LOG_W'(1);
    end
    upd_tick = upd_tick + TICK_W'(1);
  endtask

  // query: the addressed entry and the three after it, wrapping past the end
  function automatic quad_t peek_four(input logic [CTX_W-1:0] addr);
    quad_t q;
    for (int k = 0; k < 4; k++) begin
      q[k] = count_of(log_tbl[TBL_AW'(int'(addr) + k)]);
    end
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sampled at the rising edge. The result strobe is checked first,
  // then a command transfer on the same edge updates the predictor. The
  // behavioural table is cleared while reset is held.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    quad_t got;
    quad_t want;
    if (!rst_ni) begin
      foreach (log_tbl[i]) log_tbl[i] = '0;
      upd_tick = '0;
    end else begin
      if (valid_o) begin
        got = {count_first_o, count_second_o, count_third_o, count_fourth_o};
        if (counts_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with no query outstanding", result_cnt));
        end else begin
          want = counts_due.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("result %0d count[%0d]: got %h want %h",
                                        result_cnt, k, got[k], want[k]));
            end
          end
        end
        result_cnt++;
      end
      if (start_i && !busy_o) begin
        if (mode_i == MODE_QUERY) begin
          counts_due.push_back(fixed_use ? fixed_quad : peek_four(context_req_i));
        end else begin
          bump_counter(context_req_i);
        end
      end
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d queries outstanding", cyc_cnt,
               counts_due.size());
      $display("FAIL log_counter_context_table");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A transfer is taken on the
  // rising edge with start_i high and busy_o low; start_i stays high across
  // back-to-back transfers.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic md, input logic [CTX_W-1:0] ctx, input logic fx,
                          input quad_t fq, input bit may_idle);
    int unsigned gap;
    gap = 0;
    if (may_idle && ($urandom_range(0, 99) < 16)) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    mode_i        <= md;
    context_req_i <= ctx;
    fixed_use     <= fx;
    fixed_quad    <= fq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // hold off the sender until every outstanding query has come back
  task automatic drain_wait();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (counts_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [CTX_W-1:0] hot_ctx [8];
    logic [CTX_W-1:0] ctx;
    logic             md;
    int unsigned      pick;
    int unsigned      calm_lo;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    mode_i        = MODE_UPDATE;
    context_req_i = '0;
    fixed_use     = 1'b0;
    fixed_quad    = '0;

    // Directed part. Typed rows follow the tick by hand: three updates of
    // entry 0 at ticks 0..2 give log value 2 (count 3), one update of the top
    // entry at tick 3 gives count 1. Queries near the top check wrap-around.
    // Saturation at log value 63 needs some 2^62 updates and tick wrap 2^64, so they
    // sit in the predictor only and lie beyond any run.
    dir_rows = '{
      '{MODE_QUERY,  14'h0000, 1'b1, {63'd0, 63'd0, 63'd0, 63'd0}},  // table clear
      '{MODE_QUERY,  14'h3FFF, 1'b1, {63'd0, 63'd0, 63'd0, 63'd0}},  // clear, wrapping
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},                             // tick odd: no bump
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},
      '{MODE_QUERY,  14'h3FFF, 1'b1, {63'd0, 63'd3, 63'd0, 63'd0}},
      '{MODE_QUERY,  14'h0000, 1'b1, {63'd3, 63'd0, 63'd0, 63'd0}},
      '{MODE_UPDATE, 14'h3FFF, 1'b0, '0},
      '{MODE_QUERY,  14'h3FFD, 1'b1, {63'd0, 63'd0, 63'd1, 63'd3}},
      '{MODE_QUERY,  14'h3FFE, 1'b1, {63'd0, 63'd1, 63'd3, 63'd0}},
      '{MODE_UPDATE, 14'h2AAA, 1'b0, '0},
      '{MODE_UPDATE, 14'h1555, 1'b0, '0},
      '{MODE_QUERY,  14'h2AA9, 1'b0, '0},
      '{MODE_QUERY,  14'h1555, 1'b0, '0},
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},
      '{MODE_UPDATE, 14'h0000, 1'b0, '0},
      '{MODE_QUERY,  14'h0000, 1'b0, '0},
      '{MODE_QUERY,  14'h3FFF, 1'b0, '0},
      '{MODE_UPDATE, 14'h1FFF, 1'b0, '0},
      '{MODE_QUERY,  14'h1FFE, 1'b0, '0}
    };

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // the clearing pass holds busy_o high; the first transfer simply waits
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].mode, dir_rows[i].ctx, dir_rows[i].fixed, dir_rows[i].counts,
               1'b1);
    end
    drain_wait();

    // Random part: updates mostly hammer a small hot set so that log values
    // climb, queries mostly straddle hot entries in any of the four slots.
    // The rest is scattered updates and queries over the full index range,
    // plus queries pinned to the wrap boundary.
    foreach (hot_ctx[i]) hot_ctx[i] = CTX_W'($urandom_range(0, TBL_DEPTH - 1));
    hot_ctx[0] = 14'h3FFF;
    hot_ctx[1] = 14'h0000;
    calm_lo    = $urandom_range(300, 700);

    for (int unsigned i = 0; i < RAND_N; i++) begin
      pick = $urandom_range(0, 99);
      ctx  = hot_ctx[3'($urandom_range(0, 7))];
      md   = MODE_UPDATE;
      if (pick < 60) begin
        md = MODE_UPDATE;
      end else if (pick < 70) begin
        ctx = CTX_W'($urandom_range(0, 16383));
      end else if (pick < 90) begin
        md  = MODE_QUERY;
        ctx = ctx - CTX_W'($urandom_range(0, 3));
      end else if (pick < 96) begin
        md  = MODE_QUERY;
        ctx = CTX_W'($urandom_range(0, 16383));
      end else begin
        md  = MODE_QUERY;
        ctx = 14'h3FFF - CTX_W'($urandom_range(0, 3));
      end
      send_cmd(md, ctx, 1'b0, '0, !((i >= calm_lo) && (i < calm_lo + CALM_LEN)));
      if ((i % 250) == 249) drain_wait();
    end

    drain_wait();
    repeat (END_TAIL) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS log_counter_context_table");
    end else begin
      $display("FAIL log_counter_context_table");
    end
    $finish;
  end

endmodule
